// ===== src/frc_pkg.sv =====
// ----------------------------------------------------------------------------
// frc_pkg: shared types and codes of the fabric reachability classifier
// Holds item action codes, reach classes, CSR indexes and the command that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package frc_pkg;

   // upper bounds of the parameter ranges; command fields are sized for them
   localparam int SLOT_W_MAX = 9;
   localparam int ID_W_MAX   = 32;
   localparam int ADDR_W_MAX = 17;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_ADD   = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   localparam logic [1:0] OP_NOP   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_ADD   = 2'd2;
   localparam logic [1:0] OP_QUERY = 2'd3;

   localparam logic [2:0] RC_SAME           = 3'd0;
   localparam logic [2:0] RC_DIRECT_LS      = 3'd1;
   localparam logic [2:0] RC_DIRECT_PEER    = 3'd2;
   localparam logic [2:0] RC_VIA_PEER       = 3'd3;
   localparam logic [2:0] RC_ONE_SPINE      = 3'd4;
   localparam logic [2:0] RC_MULTI_SPINE    = 3'd5;
   localparam logic [2:0] RC_SPINE_VIA_LEAF = 3'd6;
   localparam logic [2:0] RC_UNREACHABLE    = 3'd7;

   localparam logic CSR_LEAF_COUNT  = 1'b0;
   localparam logic CSR_SPINE_COUNT = 1'b1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_UNKNOWN = 1'b1;

   typedef struct packed {
      logic [1:0]            op;
      logic                  status;
      logic [SLOT_W_MAX-1:0] slot_a;
      logic [SLOT_W_MAX-1:0] slot_b;
      logic [ADDR_W_MAX-1:0] rec_addr;
      logic [ID_W_MAX-1:0]   link_id;
      logic                  link_ls;
      logic                  pair_same;
      logic                  out_of_store;
      logic                  a_spine;
      logic                  b_spine;
   } cmd_type;

endpackage

// ===== src/frc_if.sv =====
// ----------------------------------------------------------------------------
// frc interfaces: request, response and CSR channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface frc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic       first_is_spine;
   logic [5:0] first_index;
   logic       second_is_spine;
   logic [5:0] second_index;
   logic [15:0] link_number;
   logic       link_is_leaf_spine;
   logic       link_enabled;

   modport source (output valid, action, first_is_spine, first_index, second_is_spine,
                   second_index, link_number, link_is_leaf_spine, link_enabled,
                   input ready);
   modport sink (input valid, action, first_is_spine, first_index, second_is_spine,
                 second_index, link_number, link_is_leaf_spine, link_enabled,
                 output ready);
endinterface

interface frc_rsp_if;
   logic       valid;
   logic       ready;
   logic       status;
   logic [2:0] reach_class;

   modport source (output valid, status, reach_class, input ready);
   modport sink (input valid, status, reach_class, output ready);
endinterface

interface frc_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [6:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/frc_queue.sv =====
// ----------------------------------------------------------------------------
// frc_queue: two-entry command queue
// Decouples the front end from the back end.
// ----------------------------------------------------------------------------
module frc_queue
   import frc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    full,
   output logic    empty
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign head_cmd = entry_ff[rd_ptr_ff];
   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== src/frc_front.sv =====
// ----------------------------------------------------------------------------
// frc_front: item intake and classification
// Holds the count registers, maps nodes to store slots, checks endpoints
// and turns each item into a back-end command.
// ----------------------------------------------------------------------------
module frc_front
   import frc_pkg::*;
#(
   parameter int MAX_LEAVES   = 64,
   parameter int MAX_SPINES   = 16,
   parameter int LINK_ID_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   frc_req_if.sink       req_ch,
   frc_csr_if.sink       csr_ch,
   input  logic          q_full,
   input  logic          init_busy,
   output logic          push,
   output cmd_type       push_cmd
);

   localparam int N  = MAX_LEAVES + MAX_SPINES;
   localparam int SW = $clog2(N);
   localparam int AW = $clog2(N * N);

   logic [6:0] leaf_count_ff;
   logic [4:0] spine_count_ff;

   logic          a_in, b_in, a_ok, b_ok;
   logic [SW-1:0] slot_a, slot_b, slot_lo, slot_hi;
   logic [AW-1:0] rec_addr;
   logic [LINK_ID_BITS-1:0] link_id;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_count_ff  <= 7'd0;
         spine_count_ff <= 5'd0;
      end else if (csr_ch.valid) begin
         if (csr_ch.index == CSR_LEAF_COUNT) begin
            leaf_count_ff <= csr_ch.data;
         end else begin
            spine_count_ff <= csr_ch.data[4:0];
         end
      end
   end

   assign req_ch.ready = !q_full && !init_busy;
   assign push         = req_ch.valid && req_ch.ready;

   // map each endpoint to a slot; leaves first, spines after them
   always_comb begin
      a_in   = 1'b0;
      b_in   = 1'b0;
      slot_a = '0;
      slot_b = '0;
      if (req_ch.first_is_spine) begin
         if (int'(req_ch.first_index) < MAX_SPINES) begin
            a_in   = 1'b1;
            slot_a = SW'(MAX_LEAVES + int'(req_ch.first_index));
         end
      end else if (int'(req_ch.first_index) < MAX_LEAVES) begin
         a_in   = 1'b1;
         slot_a = SW'(int'(req_ch.first_index));
      end
      if (req_ch.second_is_spine) begin
         if (int'(req_ch.second_index) < MAX_SPINES) begin
            b_in   = 1'b1;
            slot_b = SW'(MAX_LEAVES + int'(req_ch.second_index));
         end
      end else if (int'(req_ch.second_index) < MAX_LEAVES) begin
         b_in   = 1'b1;
         slot_b = SW'(int'(req_ch.second_index));
      end
   end

   assign a_ok = a_in && (req_ch.first_is_spine ?
                          ({1'b0, req_ch.first_index} < {2'b00, spine_count_ff}) :
                          ({1'b0, req_ch.first_index} < leaf_count_ff));
   assign b_ok = b_in && (req_ch.second_is_spine ?
                          ({1'b0, req_ch.second_index} < {2'b00, spine_count_ff}) :
                          ({1'b0, req_ch.second_index} < leaf_count_ff));

   // record store keeps one entry per unordered pair
   assign slot_lo  = (slot_a < slot_b) ? slot_a : slot_b;
   assign slot_hi  = (slot_a < slot_b) ? slot_b : slot_a;
   assign rec_addr = AW'(int'(slot_lo) * N + int'(slot_hi));
   assign link_id  = LINK_ID_BITS'(32'(req_ch.link_number));

   always_comb begin
      push_cmd              = '0;
      push_cmd.slot_a       = SLOT_W_MAX'(slot_a);
      push_cmd.slot_b       = SLOT_W_MAX'(slot_b);
      push_cmd.rec_addr     = ADDR_W_MAX'(rec_addr);
      push_cmd.link_id      = ID_W_MAX'(link_id);
      push_cmd.link_ls      = req_ch.link_is_leaf_spine;
      push_cmd.a_spine      = req_ch.first_is_spine;
      push_cmd.b_spine      = req_ch.second_is_spine;
      push_cmd.pair_same    = (req_ch.first_is_spine == req_ch.second_is_spine) &&
                              (req_ch.first_index == req_ch.second_index);
      push_cmd.out_of_store = !a_in || !b_in;
      push_cmd.status       = STATUS_OK;
      push_cmd.op           = OP_NOP;
      case (req_ch.action)
         ACT_CLEAR: push_cmd.op = OP_CLEAR;
         ACT_ADD: begin
            if (req_ch.link_enabled) begin
               if (a_ok && b_ok) begin
                  push_cmd.op = OP_ADD;
               end else begin
                  push_cmd.status = STATUS_UNKNOWN;
               end
            end
         end
         ACT_QUERY: push_cmd.op = OP_QUERY;
         default:   push_cmd.op = OP_NOP;
      endcase
   end

endmodule

// ===== src/frc_back.sv =====
// ----------------------------------------------------------------------------
// frc_back: link store and command sequencer
// Holds the adjacency rows and the lowest-link records, carries out clear,
// add and query commands and drives the response register.
// ----------------------------------------------------------------------------
module frc_back
   import frc_pkg::*;
#(
   parameter int MAX_LEAVES   = 64,
   parameter int MAX_SPINES   = 16,
   parameter int LINK_ID_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  head_cmd,
   input  logic     q_empty,
   output logic     pop,
   output logic     init_busy,
   frc_rsp_if.source rsp_ch
);

   localparam int N  = MAX_LEAVES + MAX_SPINES;
   localparam int SW = $clog2(N);
   localparam int AW = $clog2(N * N);
   localparam int RW = 2 * N;
   localparam logic [N-1:0] SPINE_MASK = {{MAX_SPINES{1'b1}}, {MAX_LEAVES{1'b0}}};

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_CLEAR = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_ADD_A = 3'd4;
   localparam logic [2:0] ST_ADD_B = 3'd5;
   localparam logic [2:0] ST_QUERY = 3'd6;
   localparam logic [2:0] ST_FIN   = 3'd7;

   // row layout: [N-1:0] leaf-spine link bits, [2N-1:N] peer link bits
   logic [RW-1:0]           row_mem [N];
   logic [LINK_ID_BITS:0]   rec_mem [N*N];

   logic [2:0]            state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [SW-1:0]         cnt_ff, cnt_in;
   logic [RW-1:0]         row_a_ff, row_b_ff;
   logic [LINK_ID_BITS:0] rec_ff;
   logic                  res_status_ff, res_status_in;
   logic [2:0]            res_class_ff, res_class_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_status_ff;
   logic [2:0]            rsp_class_ff;

   logic                  row_we, rec_we, out_free, load_out;
   logic [SW-1:0]         row_waddr, slot_a, slot_b;
   logic [RW-1:0]         row_wdata;
   logic [AW-1:0]         rec_addr;
   logic [LINK_ID_BITS-1:0] link_id;

   logic [N-1:0] la, pa, lb, pb, link_a, link_b, common;
   logic         linked_ab, upd_rec;
   logic [2:0]   q_class;

   assign slot_a   = cmd_ff.slot_a[SW-1:0];
   assign slot_b   = cmd_ff.slot_b[SW-1:0];
   assign rec_addr = cmd_ff.rec_addr[AW-1:0];
   assign link_id  = cmd_ff.link_id[LINK_ID_BITS-1:0];

   assign la     = row_a_ff[N-1:0];
   assign pa     = row_a_ff[RW-1:N];
   assign lb     = row_b_ff[N-1:0];
   assign pb     = row_b_ff[RW-1:N];
   assign link_a = la | pa;
   assign link_b = lb | pb;
   assign common = la & lb & SPINE_MASK;

   assign linked_ab = link_a[slot_b];
   assign upd_rec   = !linked_ab || (link_id < rec_ff[LINK_ID_BITS-1:0]);

   // rows are symmetric, so "neighbor p links to y" is bit p of row y
   always_comb begin
      q_class = RC_UNREACHABLE;
      if (cmd_ff.pair_same) begin
         q_class = RC_SAME;
      end else if (cmd_ff.out_of_store) begin
         q_class = RC_UNREACHABLE;
      end else if (linked_ab) begin
         q_class = rec_ff[LINK_ID_BITS] ? RC_DIRECT_LS : RC_DIRECT_PEER;
      end else if (!cmd_ff.a_spine && !cmd_ff.b_spine) begin
         if (|(common & (common - N'(1)))) begin
            q_class = RC_MULTI_SPINE;
         end else if (|common) begin
            q_class = RC_ONE_SPINE;
         end else if (|(pa & link_b) || |(pb & link_a)) begin
            q_class = RC_VIA_PEER;
         end
      end else if (cmd_ff.a_spine && cmd_ff.b_spine) begin
         if (|(la & link_b)) begin
            q_class = RC_SPINE_VIA_LEAF;
         end
      end else if (cmd_ff.a_spine) begin
         if (|(pb & link_a)) begin
            q_class = RC_VIA_PEER;
         end
      end else if (|(pa & link_b)) begin
         q_class = RC_VIA_PEER;
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign init_busy = (state_ff == ST_INIT);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_class_in  = res_class_ff;
      pop           = 1'b0;
      load_out      = 1'b0;
      row_we        = 1'b0;
      row_waddr     = cnt_ff;
      row_wdata     = '0;
      rec_we        = 1'b0;
      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            row_we = 1'b1;
            cnt_in = cnt_ff + SW'(1);
            if (cnt_ff == SW'(N - 1)) begin
               cnt_in   = '0;
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_FIN;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               pop           = 1'b1;
               cmd_in        = head_cmd;
               res_status_in = head_cmd.status;
               res_class_in  = RC_SAME;
               case (head_cmd.op)
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_ADD:   state_in = ST_READ;
                  OP_QUERY: state_in = ST_READ;
                  default:  state_in = ST_FIN;
               endcase
            end
         end
         ST_READ: begin
            state_in = (cmd_ff.op == OP_ADD) ? ST_ADD_A : ST_QUERY;
         end
         ST_ADD_A: begin
            row_we    = 1'b1;
            row_waddr = slot_a;
            row_wdata = row_a_ff |
                        (RW'(1) << (cmd_ff.link_ls ? int'(slot_b) : N + int'(slot_b)));
            rec_we    = upd_rec;
            state_in  = ST_ADD_B;
         end
         ST_ADD_B: begin
            row_we    = 1'b1;
            row_waddr = slot_b;
            row_wdata = row_b_ff |
                        (RW'(1) << (cmd_ff.link_ls ? int'(slot_a) : N + int'(slot_a)));
            state_in  = ST_FIN;
         end
         ST_QUERY: begin
            res_class_in = q_class;
            state_in     = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_waddr] <= row_wdata;
      end
      if (rec_we) begin
         rec_mem[rec_addr] <= {cmd_ff.link_ls, link_id};
      end
      if (state_ff == ST_READ) begin
         row_a_ff <= row_mem[slot_a];
         row_b_ff <= row_mem[slot_b];
         rec_ff   <= rec_mem[rec_addr];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      res_status_ff <= res_status_in;
      res_class_ff  <= res_class_in;
      if (load_out) begin
         rsp_status_ff <= res_status_ff;
         rsp_class_ff  <= res_class_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.reach_class = rsp_class_ff;

endmodule

// ===== src/fabric_reachability_classifier.sv =====
// Fabric reachability classifier. Each item clears the link store, adds one
// link between a leaf or spine pair, or asks how two nodes reach each other;
// every item yields exactly one response item. In the back end an add steps
// through dequeue, row read, two row writes and response load, a query through
// dequeue, row read, a classify step and response load; an add is longer
// because the single write port of the adjacency row memory is written twice.
// A disabled or rejected add and an unused action go from dequeue straight to
// response load. A clear sweeps the store one row per cycle, then loads the
// response. After reset the same sweep runs over every row with req_ch ready
// held low; CSR writes are taken throughout. A two-entry queue sits between
// intake and the store, so the block keeps taking items while a response waits
// on rsp_ch, until the queue is full.
// ----------------------------------------------------------------------------
// fabric_reachability_classifier: top level
// Intake front end, command queue and link-store back end.
// ----------------------------------------------------------------------------
module fabric_reachability_classifier
   import frc_pkg::*;
#(
   parameter int MAX_LEAVES   = 64,
   parameter int MAX_SPINES   = 16,
   parameter int LINK_ID_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   frc_req_if.sink   req_ch,
   frc_rsp_if.source rsp_ch,
   frc_csr_if.sink   csr_ch
);

   cmd_type push_cmd, head_cmd;
   logic    push, pop, q_full, q_empty, init_busy;

   // classify items and hold the count registers
   frc_front #(
      .MAX_LEAVES  (MAX_LEAVES),
      .MAX_SPINES  (MAX_SPINES),
      .LINK_ID_BITS(LINK_ID_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .csr_ch   (csr_ch),
      .q_full   (q_full),
      .init_busy(init_busy),
      .push     (push),
      .push_cmd (push_cmd)
   );

   // buffer commands so intake and store stall independently
   frc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .pop     (pop),
      .head_cmd(head_cmd),
      .full    (q_full),
      .empty   (q_empty)
   );

   // execute commands against the store and drive responses
   frc_back #(
      .MAX_LEAVES  (MAX_LEAVES),
      .MAX_SPINES  (MAX_SPINES),
      .LINK_ID_BITS(LINK_ID_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .q_empty  (q_empty),
      .pop      (pop),
      .init_busy(init_busy),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== src/frc_checker.sv =====
// ----------------------------------------------------------------------------
// frc_checker: port-level checks of the reachability classifier
// Watches the top-level channels; attached by bind.
// ----------------------------------------------------------------------------
module frc_checker
   import frc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_status,
   input logic [2:0] rsp_reach_class
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_reach_class))
      else $error("response changed while stalled");

   // store sweep after reset blocks intake and leaves no response
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("intake open or response pending after reset");

   // a rejected add reports no reach class
   a_status_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_reach_class == RC_SAME)
      else $error("rejected add carries a reach class");

   // intake is closed when reset is released, at the start of the store sweep
   a_sweep_hold: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("item accepted during store sweep");

endmodule

bind fabric_reachability_classifier frc_checker u_frc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_reach_class(rsp_ch.reach_class)
);

// ===== dv/fabric_reachability_classifier_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fabric_reachability_classifier_tb: self-checking testbench
// Drives clear, add and query items with random idling on both channels and
// predicts every response from a behavioral copy of the pairwise link store.
// ----------------------------------------------------------------------------
module fabric_reachability_classifier_tb;
   import frc_pkg::*;

   localparam int LEAVES    = 64;
   localparam int SPINES    = 16;
   localparam int SLOTS     = LEAVES + SPINES;
   localparam int LIMIT     = 2000000;
   localparam int IDLE_MAX  = 14;

   typedef struct packed {
      logic       status;
      logic [2:0] reach_class;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   frc_req_if req_ch ();
   frc_rsp_if rsp_ch ();
   frc_csr_if csr_ch ();

   fabric_reachability_classifier dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source),
      .csr_ch(csr_ch.sink)
   );

   // predicted link store and counts
   bit          ls_bit [SLOTS][SLOTS];
   bit          peer_bit [SLOTS][SLOTS];
   logic [15:0] low_id [SLOTS][SLOTS];
   bit          low_ls [SLOTS][SLOTS];
   int unsigned leaf_cnt;
   int unsigned spine_cnt;

   answer_type  pending_answers[$];
   int          errors;
   int          cycles;
   int          hold_off;     // long receiver stall, counted down per cycle
   bit          rsp_idle_on;  // random receiver stalls enabled

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic report(input string what);
      errors++;
      $display("ERROR @%0t: %s", $realtime, what);
   endtask

   // ---------------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------------
   function automatic int slot_of(input bit spine, input int unsigned idx);
      if (spine) return (idx < SPINES) ? LEAVES + idx : SLOTS;
      return (idx < LEAVES) ? idx : SLOTS;
   endfunction

   function automatic bit linked(input int x, input int y);
      return ls_bit[x][y] || peer_bit[x][y];
   endfunction

   function automatic void store_half(input int x, input int y, input logic [15:0] id,
                                      input bit ls);
      if (!linked(x, y) || id < low_id[x][y]) begin
         low_id[x][y] = id;
         low_ls[x][y] = ls;
      end
      if (ls) ls_bit[x][y] = 1'b1;
      else peer_bit[x][y] = 1'b1;
   endfunction

   function automatic bit via_neighbor(input int x, input int y, input bit by_ls);
      for (int p = 0; p < SLOTS; p++) begin
         if ((by_ls ? ls_bit[x][p] : peer_bit[x][p]) && linked(p, y)) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [2:0] classify_pair(input int a, input int b, input bit as,
                                                input bit bs);
      int n;
      if (a >= SLOTS || b >= SLOTS) return RC_UNREACHABLE;
      if (linked(a, b)) return low_ls[a][b] ? RC_DIRECT_LS : RC_DIRECT_PEER;
      if (!as && !bs) begin
         n = 0;
         for (int s = LEAVES; s < SLOTS; s++) if (ls_bit[a][s] && ls_bit[b][s]) n++;
         if (n >= 2) return RC_MULTI_SPINE;
         if (n == 1) return RC_ONE_SPINE;
         if (via_neighbor(a, b, 1'b0) || via_neighbor(b, a, 1'b0)) return RC_VIA_PEER;
         return RC_UNREACHABLE;
      end
      if (as && bs) return via_neighbor(a, b, 1'b1) ? RC_SPINE_VIA_LEAF : RC_UNREACHABLE;
      if (as) return via_neighbor(b, a, 1'b0) ? RC_VIA_PEER : RC_UNREACHABLE;
      return via_neighbor(a, b, 1'b0) ? RC_VIA_PEER : RC_UNREACHABLE;
   endfunction

   function automatic answer_type predict_answer(input logic [1:0] act, input bit fs,
                                                 input int fi, input bit ss, input int si,
                                                 input logic [15:0] id, input bit ls,
                                                 input bit en);
      answer_type r;
      int a, b;
      bit a_ok, b_ok;
      r = '0;
      a = slot_of(fs, fi);
      b = slot_of(ss, si);
      if (act == ACT_CLEAR) begin
         foreach (ls_bit[x, y]) begin
            ls_bit[x][y] = 1'b0;
            peer_bit[x][y] = 1'b0;
         end
      end else if (act == ACT_ADD) begin
         if (en) begin
            a_ok = a < SLOTS && fi < (fs ? spine_cnt : leaf_cnt);
            b_ok = b < SLOTS && si < (ss ? spine_cnt : leaf_cnt);
            if (!a_ok || !b_ok) r.status = STATUS_UNKNOWN;
            else begin
               store_half(a, b, id, ls);
               store_half(b, a, id, ls);
            end
         end
      end else if (act == ACT_QUERY) begin
         if (fs == ss && fi == si) r.reach_class = RC_SAME;
         else r.reach_class = classify_pair(a, b, fs, ss);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // driving
   // ---------------------------------------------------------------------------
   initial begin
      req_ch.valid = 1'b0;
      req_ch.action = ACT_CLEAR;
      req_ch.first_is_spine = 1'b0;
      req_ch.first_index = '0;
      req_ch.second_is_spine = 1'b0;
      req_ch.second_index = '0;
      req_ch.link_number = '0;
      req_ch.link_is_leaf_spine = 1'b0;
      req_ch.link_enabled = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_LEAF_COUNT;
      csr_ch.data = '0;
   end

   // send one item; the idle gap is drawn per item. Valid stays high after
   // the accepting edge so the next item can follow at once; drop it
   // before any idle gap or wait.
   task automatic send_item(input logic [1:0] act, input bit fs, input int fi, input bit ss,
                            input int si, input logic [15:0] id, input bit ls, input bit en,
                            input bit no_gap = 1'b0);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX));
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pending_answers = {pending_answers, predict_answer(act, fs, fi, ss, si, id, ls, en)};
      req_ch.valid <= 1'b1;
      req_ch.action <= act;
      req_ch.first_is_spine <= fs;
      req_ch.first_index <= fi[5:0];
      req_ch.second_is_spine <= ss;
      req_ch.second_index <= si[5:0];
      req_ch.link_number <= id;
      req_ch.link_is_leaf_spine <= ls;
      req_ch.link_enabled <= en;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SLOTS + 10) @(posedge clock);
   endtask

   // write a count register; only called while the block is idle
   task automatic write_count(input logic idx, input int unsigned value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value[6:0];
      do @(posedge clock); while (!csr_ch.ready);
      if (idx == CSR_LEAF_COUNT) leaf_cnt = value & 7'h7F;
      else spine_cnt = value & 5'h1F;
   endtask

   task automatic set_counts(input int unsigned leaves, input int unsigned spines);
      drain();
      write_count(CSR_LEAF_COUNT, leaves);
      write_count(CSR_SPINE_COUNT, spines);
      csr_ch.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // checking: receiver stalls and compares each response with the oldest
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_answers.size() == 0) report("response with nothing expected");
         else begin
            want = pending_answers.pop_front();
            if (rsp_ch.status !== want.status)
               report($sformatf("status %0b, expected %0b", rsp_ch.status, want.status));
            if (rsp_ch.reach_class !== want.reach_class)
               report($sformatf("reach_class %0d, expected %0d", rsp_ch.reach_class,
                                want.reach_class));
         end
      end
   end

   // ready may drop for a random number of cycles after each accepted response while rsp_idle_on is set
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off = hold_off - 1;
         end else if (rsp_ch.valid && rsp_ch.ready) begin
            stall = rsp_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
            if (stall > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ch.ready <= 1'b1;
         end else rsp_ch.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------
   function automatic int rand_index(input bit spine);
      // mostly in range, sometimes beyond the counts or the store
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 63);
      return spine ? $urandom_range(0, 5) : $urandom_range(0, 9);
   endfunction

   task automatic test_directed();
      set_counts(64, 16);
      send_item(ACT_QUERY, 0, 0, 0, 0, 16'h0, 0, 0);         // same node
      send_item(ACT_QUERY, 1, 63, 1, 63, 16'hFFFF, 1, 1);    // same node, outside store
      send_item(ACT_QUERY, 0, 63, 1, 15, 16'h0, 0, 0);       // empty store
      send_item(ACT_ADD, 0, 0, 1, 0, 16'h0010, 1, 1);
      send_item(ACT_ADD, 0, 0, 1, 0, 16'h0010, 0, 1);        // equal id keeps first
      send_item(ACT_ADD, 0, 0, 1, 0, 16'h0020, 0, 1);
      send_item(ACT_QUERY, 0, 0, 1, 0, 16'h0, 0, 0);         // direct leaf-spine
      send_item(ACT_ADD, 0, 1, 1, 0, 16'hFFFF, 1, 1);
      send_item(ACT_QUERY, 0, 0, 0, 1, 16'h0, 0, 0);         // one spine
      send_item(ACT_ADD, 0, 1, 1, 15, 16'h0000, 1, 1);
      send_item(ACT_ADD, 0, 0, 1, 15, 16'h0001, 1, 1);
      send_item(ACT_QUERY, 0, 1, 0, 0, 16'h0, 0, 0);         // several spines
      send_item(ACT_QUERY, 1, 0, 1, 15, 16'h0, 0, 0);        // spine via leaf
      send_item(ACT_ADD, 0, 63, 0, 1, 16'h0005, 0, 1);       // peer link
      send_item(ACT_QUERY, 0, 63, 0, 1, 16'h0, 0, 0);        // direct peer
      send_item(ACT_QUERY, 0, 63, 0, 0, 16'h0, 0, 0);
      send_item(ACT_QUERY, 1, 0, 0, 63, 16'h0, 0, 0);        // via peer
      send_item(ACT_ADD, 0, 5, 0, 5, 16'h0007, 0, 1);        // self link
      send_item(ACT_QUERY, 0, 5, 0, 5, 16'h0, 0, 0);
      send_item(ACT_ADD, 1, 16, 0, 0, 16'h0002, 1, 1);       // beyond store, rejected
      send_item(ACT_ADD, 1, 63, 0, 64 - 1, 16'h0003, 1, 0);  // disabled, unknown ignored
      send_item(2'd3, 1, 63, 1, 63, 16'hFFFF, 1, 1);         // unused action
      set_counts(0, 0);
      send_item(ACT_ADD, 0, 0, 1, 0, 16'h0001, 1, 1);        // counts zero, rejected
      send_item(ACT_QUERY, 0, 1, 0, 0, 16'h0, 0, 0);         // old links still used
      send_item(ACT_CLEAR, 1, 63, 1, 63, 16'hFFFF, 1, 1);
      send_item(ACT_QUERY, 0, 1, 0, 0, 16'h0, 0, 0);
   endtask

   // build small random fabrics and query them as they grow; sizes vary per phase
   task automatic test_random(input int items);
      int sent;
      int r;
      bit fs, ss;
      sent = 0;
      while (sent < items) begin
         set_counts($urandom_range(0, 3) == 0 ? $urandom_range(0, 64) : $urandom_range(4, 10),
                    $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : $urandom_range(2, 6));
         send_item(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom);
         sent++;
         repeat ($urandom_range(40, 90)) begin
            r = $urandom_range(0, 99);
            fs = $urandom;
            ss = (r < 30) ? ~fs : $urandom;
            if (r < 50)
               send_item(ACT_ADD, fs, rand_index(fs), ss, rand_index(ss),
                         ($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom), $urandom,
                         $urandom_range(0, 7) != 0);
            else if (r < 97)
               send_item(ACT_QUERY, fs, rand_index(fs), ss, rand_index(ss), $urandom,
                         $urandom, $urandom);
            else
               send_item($urandom_range(0, 3), fs, $urandom_range(0, 63), ss,
                         $urandom_range(0, 63), $urandom, $urandom, $urandom);
            sent++;
         end
      end
   endtask

   // stall the receiver long enough for the queue to fill and stall intake, then pause
   // the sender until every response is back; then send adds with receiver stalls off
   task automatic test_backpressure();
      set_counts(8, 4);
      hold_off = 300;
      repeat (20) send_item(ACT_QUERY, 0, $urandom_range(0, 7), 1, $urandom_range(0, 3),
                            $urandom, $urandom, $urandom, 1'b1);
      drain();
      rsp_idle_on = 1'b0;
      repeat (30) send_item(ACT_ADD, 0, $urandom_range(0, 7), 1, $urandom_range(0, 3),
                            $urandom, $urandom, 1'b1, 1'b1);
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      errors = 0;
      hold_off = 0;
      rsp_idle_on = 1'b1;
      leaf_cnt = 0;
      spine_cnt = 0;
      foreach (ls_bit[x, y]) begin
         ls_bit[x][y] = 1'b0;
         peer_bit[x][y] = 1'b0;
         low_id[x][y] = '0;
         low_ls[x][y] = 1'b0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random(950);
      drain();
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
src/frc_pkg.sv
src/frc_if.sv
src/frc_queue.sv
src/frc_front.sv
src/frc_back.sv
src/fabric_reachability_classifier.sv
src/frc_checker.sv
dv/fabric_reachability_classifier_tb.sv
